// ----- design/ccfp_pkg.sv -----
package ccfp_pkg;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_MSB  = 16'h8000;

  typedef enum logic [2:0] {
    PH_HUNT   = 3'd0,
    PH_CMD    = 3'd1,
    PH_LEN_LO = 3'd2,
    PH_LEN_HI = 3'd3,
    PH_DATA   = 3'd4,
    PH_CRC_LO = 3'd5,
    PH_CRC_HI = 3'd6
  } ph_t;

  typedef enum logic [1:0] {
    EM_IDLE = 2'd0,
    EM_LOAD = 2'd1,
    EM_HOLD = 2'd2
  } em_t;

  typedef enum logic [0:0] {
    CFG_START_BYTE = 1'b0,
    CFG_GAP_LIMIT  = 1'b1
  } cfg_idx_t;

  // Start request for the payload emitter, raised once per good frame
  typedef struct packed {
    logic       go;
    logic [7:0] cmd;
    logic [6:0] len;
  } emit_req_t;

  // CRC-16/CCITT-FALSE, one byte, MSB first
  function automatic logic [15:0] crc16_byte(logic [15:0] crc_in, logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_MSB) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ----- design/ccfp_if.sv -----
interface ccfp_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  rx_byte;
  logic [31:0] now_ms;

  modport source (output valid, output rx_byte, output now_ms, input ready);
  modport sink   (input valid, input rx_byte, input now_ms, output ready);
endinterface

interface ccfp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_command;
  logic [6:0] frame_length;
  logic [7:0] data_byte;
  logic       has_data;
  logic       last;

  modport source (output valid, output frame_command, output frame_length,
                  output data_byte, output has_data, output last, input ready);
  modport sink   (input valid, input frame_command, input frame_length,
                  input data_byte, input has_data, input last, output ready);
endinterface

// ----- design/crc_checked_frame_parser_top.sv -----
// Channel  Dir  Handshake     Payload
// in_if    in   valid/ready   rx_byte[7:0], now_ms[31:0]
// out_if   out  valid/ready   frame_command, frame_length, data_byte, has_data, last
// cfg      in   cfg_we        cfg_index (0 start byte, 1 gap limit), cfg_data[31:0]
//
// Each byte is first registered, then parsed and folded into the CRC; no new byte is
// accepted while one is pending. A good frame then blocks input while the payload
// store is drained: each payload byte passes the memory read and the output register,
// held while out_if.ready stays low; a zero-length frame emits just its marker.
// Synchronous active-low reset; the payload store needs no clearing pass.
module crc_checked_frame_parser_top #(
  parameter int MAX_PAYLOAD = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  ccfp_in_if.sink             in_if,
  ccfp_out_if.source          out_if,
  input  logic                cfg_we,
  input  ccfp_pkg::cfg_idx_t  cfg_index,
  input  logic [31:0]         cfg_data
);
  import ccfp_pkg::*;

  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int LW = $clog2(MAX_PAYLOAD + 1);

  logic [7:0]  start_byte_r;
  logic [31:0] gap_limit_r;

  logic        pend_r;
  logic [7:0]  byte_r;
  logic [31:0] now_r;
  logic [31:0] last_time_r;

  ph_t         phase_r, phase_nxt, eff_phase;
  logic [7:0]  cmd_r, cmd_nxt;
  logic [7:0]  len_lo_r, len_lo_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic [LW-1:0] cnt_r, cnt_nxt;
  logic [7:0]  crc_lo_r, crc_lo_nxt;
  logic [15:0] crc_r, crc_nxt;

  logic        timeout;
  logic [15:0] crc_upd;
  logic [15:0] full_len;
  logic [LW:0] cnt_inc;
  logic        wr_en;
  emit_req_t   emit_req;
  logic        emit_busy;

  assign in_if.ready = !pend_r && !emit_busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_byte_r <= 8'd0;
      gap_limit_r  <= 32'd100;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_START_BYTE: start_byte_r <= cfg_data[7:0];
        CFG_GAP_LIMIT:  gap_limit_r  <= cfg_data;
      endcase
    end
  end

  assign timeout   = (phase_r != PH_HUNT) && (32'(now_r - last_time_r) > gap_limit_r);
  assign eff_phase = timeout ? PH_HUNT : phase_r;
  assign crc_upd   = crc16_byte((eff_phase == PH_CMD) ? CRC_INIT : crc_r, byte_r);
  assign full_len  = {byte_r, len_lo_r};
  assign cnt_inc   = (LW + 1)'(cnt_r) + 1'b1;

  always_comb begin
    phase_nxt    = phase_r;
    cmd_nxt      = cmd_r;
    len_lo_nxt   = len_lo_r;
    len_nxt      = len_r;
    cnt_nxt      = cnt_r;
    crc_lo_nxt   = crc_lo_r;
    crc_nxt      = crc_r;
    wr_en        = 1'b0;
    emit_req.go  = 1'b0;
    emit_req.cmd = cmd_r;
    emit_req.len = 7'(len_r);
    if (pend_r) begin
      unique case (eff_phase)
        PH_HUNT: begin
          phase_nxt = (byte_r == start_byte_r) ? PH_CMD : PH_HUNT;
        end
        PH_CMD: begin
          cmd_nxt   = byte_r;
          crc_nxt   = crc_upd;
          phase_nxt = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          len_lo_nxt = byte_r;
          crc_nxt    = crc_upd;
          phase_nxt  = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          crc_nxt = crc_upd;
          cnt_nxt = '0;
          len_nxt = LW'(full_len);
          if (full_len > 16'(MAX_PAYLOAD)) begin
            phase_nxt = PH_HUNT;
          end else if (full_len == 16'd0) begin
            phase_nxt = PH_CRC_LO;
          end else begin
            phase_nxt = PH_DATA;
          end
        end
        PH_DATA: begin
          wr_en   = 1'b1;
          crc_nxt = crc_upd;
          cnt_nxt = LW'(cnt_inc);
          if (cnt_inc >= (LW + 1)'(len_r)) begin
            phase_nxt = PH_CRC_LO;
          end
        end
        PH_CRC_LO: begin
          crc_lo_nxt = byte_r;
          phase_nxt  = PH_CRC_HI;
        end
        PH_CRC_HI: begin
          emit_req.go = ({byte_r, crc_lo_r} == crc_r);
          phase_nxt   = PH_HUNT;
        end
        default: begin
          phase_nxt = (byte_r == start_byte_r) ? PH_CMD : PH_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HUNT;
      pend_r      <= 1'b0;
      last_time_r <= 32'd0;
    end else begin
      phase_r <= phase_nxt;
      if (in_if.valid && in_if.ready) begin
        pend_r <= 1'b1;
      end else begin
        pend_r <= 1'b0;
      end
      if (pend_r) begin
        last_time_r <= now_r;
      end
    end
    if (in_if.valid && in_if.ready) begin
      byte_r <= in_if.rx_byte;
      now_r  <= in_if.now_ms;
    end
    cmd_r    <= cmd_nxt;
    len_lo_r <= len_lo_nxt;
    len_r    <= len_nxt;
    cnt_r    <= cnt_nxt;
    crc_lo_r <= crc_lo_nxt;
    crc_r    <= crc_nxt;
  end

  ccfp_emit #(
    .MAX_PAYLOAD (MAX_PAYLOAD),
    .AW          (AW)
  ) u_emit (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_en),
    .wr_addr (cnt_r[AW-1:0]),
    .wr_data (byte_r),
    .req     (emit_req),
    .busy    (emit_busy),
    .out_if  (out_if)
  );

`ifndef SYNTH
  a_no_input_while_draining: assert property (@(posedge clk) disable iff (!rst_n)
    emit_busy |-> !in_if.ready)
    else $error("input accepted while payload drains");

  a_output_only_when_draining: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid |-> emit_busy)
    else $error("result shown with emitter idle");

  a_go_from_crc_phase: assert property (@(posedge clk) disable iff (!rst_n)
    emit_req.go |-> (pend_r && phase_r == PH_CRC_HI && !emit_busy))
    else $error("emit started outside the CRC check");

  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (cnt_r < len_r))
    else $error("payload write beyond frame length");
`endif

endmodule

// ----- design/ccfp_emit.sv -----
module ccfp_emit #(
  parameter int MAX_PAYLOAD = 64,
  parameter int AW          = 6
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  logic [7:0]           wr_data,
  input  ccfp_pkg::emit_req_t  req,
  output logic                 busy,
  ccfp_out_if.source           out_if
);
  import ccfp_pkg::*;

  logic [7:0] pay_mem [MAX_PAYLOAD];
  logic [7:0] rd_data_r;
  logic [AW-1:0] rd_addr;

  em_t         state_r, state_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [7:0]  cmd_r, cmd_nxt;
  logic [6:0]  len_r, len_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_cmd_r, out_cmd_nxt;
  logic [6:0]  out_len_r, out_len_nxt;
  logic [7:0]  out_data_r, out_data_nxt;
  logic        out_has_r, out_has_nxt;
  logic        out_last_r, out_last_nxt;
  logic        idx_is_last;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      pay_mem[wr_addr] <= wr_data;
    end
    rd_data_r <= pay_mem[rd_addr];
  end

  assign idx_is_last = (8'(idx_r) + 8'd1) == 8'(len_r);

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    cmd_nxt       = cmd_r;
    len_nxt       = len_r;
    out_valid_nxt = out_valid_r;
    out_cmd_nxt   = out_cmd_r;
    out_len_nxt   = out_len_r;
    out_data_nxt  = out_data_r;
    out_has_nxt   = out_has_r;
    out_last_nxt  = out_last_r;
    rd_addr       = idx_r;
    unique case (state_r)
      EM_IDLE: begin
        // entry 0 is read every idle cycle so it is ready on the first load
        rd_addr = '0;
        if (req.go) begin
          cmd_nxt = req.cmd;
          len_nxt = req.len;
          idx_nxt = '0;
          if (req.len == 7'd0) begin
            out_valid_nxt = 1'b1;
            out_cmd_nxt   = req.cmd;
            out_len_nxt   = 7'd0;
            out_data_nxt  = 8'd0;
            out_has_nxt   = 1'b0;
            out_last_nxt  = 1'b1;
            state_nxt     = EM_HOLD;
          end else begin
            state_nxt = EM_LOAD;
          end
        end
      end
      EM_LOAD: begin
        out_valid_nxt = 1'b1;
        out_cmd_nxt   = cmd_r;
        out_len_nxt   = len_r;
        out_data_nxt  = rd_data_r;
        out_has_nxt   = 1'b1;
        out_last_nxt  = idx_is_last;
        state_nxt     = EM_HOLD;
      end
      EM_HOLD: begin
        // prefetch the next entry while the transaction waits
        rd_addr = out_last_r ? idx_r : AW'(idx_r + 1'b1);
        if (out_if.ready) begin
          out_valid_nxt = 1'b0;
          if (out_last_r) begin
            state_nxt = EM_IDLE;
          end else begin
            idx_nxt   = AW'(idx_r + 1'b1);
            state_nxt = EM_LOAD;
          end
        end
      end
      default: begin
        out_valid_nxt = 1'b0;
        state_nxt     = EM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= EM_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r      <= idx_nxt;
    cmd_r      <= cmd_nxt;
    len_r      <= len_nxt;
    out_cmd_r  <= out_cmd_nxt;
    out_len_r  <= out_len_nxt;
    out_data_r <= out_data_nxt;
    out_has_r  <= out_has_nxt;
    out_last_r <= out_last_nxt;
  end

  assign busy                 = state_r != EM_IDLE;
  assign out_if.valid         = out_valid_r;
  assign out_if.frame_command = out_cmd_r;
  assign out_if.frame_length  = out_len_r;
  assign out_if.data_byte     = out_data_r;
  assign out_if.has_data      = out_has_r;
  assign out_if.last          = out_last_r;

endmodule
